>>> rtl/safl_pkg.sv
// Shared constants, codes and types for the slot allocator.
// Used by the channel interfaces, the controller, the datapath and the checker.
package safl_pkg;

    localparam int ROWS_PER_PAGE = 256;
    localparam int MAX_PAGES     = 4;
    localparam int SLOT_CAP      = ROWS_PER_PAGE * MAX_PAGES;

    localparam int ID_W   = 10;               // slot id field width
    localparam int CNT_W  = ID_W + 1;         // head, free count, high-water mark
    localparam int WORD_W = 32;               // payload word width
    localparam int SLOTS  = 2 ** ID_W;        // every id the field can name

    localparam logic [CNT_W-1:0] CAP_CNT    = CNT_W'(SLOT_CAP);
    localparam logic [CNT_W-1:0] HEAD_EMPTY = '1;

    typedef enum logic {
        OP_ALLOC   = 1'b0,
        OP_RELEASE = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_BAD_ID = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic capture;   // take the request, launch link and used-map reads
        logic commit;    // update lists and memories, load the result register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic out_busy;  // result register holds a transfer not yet taken
    } t_sts;

endpackage

>>> rtl/safl_if.sv
// Valid/ready channel interfaces for requests and responses.
// Depends on safl_pkg.
interface safl_req_if;
    import safl_pkg::*;

    logic                 valid;
    logic                 ready;
    t_op                  op;
    logic [WORD_W-1:0]    page_word;
    logic [WORD_W-1:0]    offset_word;
    logic [ID_W-1:0]      slot_id;

    modport source (output valid, op, page_word, offset_word, slot_id, input ready);
    modport sink   (input valid, op, page_word, offset_word, slot_id, output ready);
endinterface

interface safl_rsp_if;
    import safl_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [ID_W-1:0]      alloc_id;
    t_status              status;

    modport source (output valid, alloc_id, status, input ready);
    modport sink   (input valid, alloc_id, status, output ready);
endinterface

>>> rtl/safl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module safl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/safl_ctrl.sv
// Controller: two-state sequencer that issues capture and commit commands.
// Depends on safl_pkg.
module safl_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  safl_pkg::t_sts  i_sts,
    output safl_pkg::t_cmd  o_cmd
);
    import safl_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_in_ready    = 1'b0;
        o_cmd.capture = 1'b0;
        o_cmd.commit  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                // wait here while the previous result is still unclaimed
                if (!i_sts.out_busy) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end
endmodule

>>> rtl/safl_dp.sv
// Datapath: free-list head and count, bump pointer, link / used-map / payload
// memories and the result register. Depends on safl_pkg and safl_ram.
module safl_dp (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  safl_pkg::t_cmd            i_cmd,
    output safl_pkg::t_sts            o_sts,
    input  safl_pkg::t_op             i_op,
    input  logic [safl_pkg::WORD_W-1:0] i_page_word,
    input  logic [safl_pkg::WORD_W-1:0] i_offset_word,
    input  logic [safl_pkg::ID_W-1:0] i_slot_id,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [safl_pkg::ID_W-1:0] o_alloc_id,
    output safl_pkg::t_status         o_status
);
    import safl_pkg::*;

    // captured request
    t_op               r_op;
    logic [WORD_W-1:0] r_page;
    logic [WORD_W-1:0] r_offset;
    logic [ID_W-1:0]   r_slot_id;

    // list state
    logic [CNT_W-1:0]  r_free_head,  n_free_head;
    logic [CNT_W-1:0]  r_free_count, n_free_count;
    logic [CNT_W-1:0]  r_high_water, n_high_water;

    // result register
    logic              r_out_valid, n_out_valid;
    logic [ID_W-1:0]   r_alloc_id;
    t_status           r_status;

    logic [ID_W-1:0]   link_rdata;
    logic              used_rdata;

    logic              is_alloc;
    logic              pop_ok;
    logic              bump_ok;
    logic              alloc_ok;
    logic              rel_ok;
    logic [ID_W-1:0]   grant_id;
    logic              used_we;
    logic [ID_W-1:0]   used_waddr;
    logic              link_we;
    logic              store_we;
    logic [CNT_W-1:0]  slot_ext;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op      <= i_op;
            r_page    <= i_page_word;
            r_offset  <= i_offset_word;
            r_slot_id <= i_slot_id;
        end
    end

    always_comb begin
        is_alloc = (r_op == OP_ALLOC);
        slot_ext = {1'b0, r_slot_id};
        pop_ok   = (r_free_count != '0) && (r_free_head < CAP_CNT);
        bump_ok  = (r_high_water < CAP_CNT);
        grant_id = pop_ok ? r_free_head[ID_W-1:0] : r_high_water[ID_W-1:0];
        alloc_ok = is_alloc && (pop_ok || bump_ok);
        // ids below the high-water mark were all written by a bump grant,
        // so the used-map data is only relied on for an entry that has been written
        rel_ok   = !is_alloc && (slot_ext < r_high_water) && (slot_ext < CAP_CNT)
                   && used_rdata;

        used_we    = i_cmd.commit && (alloc_ok || rel_ok);
        used_waddr = is_alloc ? grant_id : r_slot_id;
        link_we    = i_cmd.commit && rel_ok;
        store_we   = i_cmd.commit && alloc_ok;
    end

    // link of the current head is read with the request, ready for a pop
    safl_ram #(.WIDTH(ID_W), .DEPTH(SLOTS)) u_link (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (r_slot_id),
        .i_wdata (r_free_head[ID_W-1:0]),
        .i_re    (i_cmd.capture),
        .i_raddr (r_free_head[ID_W-1:0]),
        .o_rdata (link_rdata)
    );

    safl_ram #(.WIDTH(1), .DEPTH(SLOTS)) u_used (
        .i_clk   (i_clk),
        .i_we    (used_we),
        .i_waddr (used_waddr),
        .i_wdata (is_alloc),
        .i_re    (i_cmd.capture),
        .i_raddr (i_slot_id),
        .o_rdata (used_rdata)
    );

    safl_ram #(.WIDTH(WORD_W), .DEPTH(SLOTS)) u_page (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (grant_id),
        .i_wdata (r_page),
        .i_re    (1'b0),
        .i_raddr ('0),
        .o_rdata ()
    );

    safl_ram #(.WIDTH(WORD_W), .DEPTH(SLOTS)) u_offset (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (grant_id),
        .i_wdata (r_offset),
        .i_re    (1'b0),
        .i_raddr ('0),
        .o_rdata ()
    );

    always_comb begin
        n_free_head  = r_free_head;
        n_free_count = r_free_count;
        n_high_water = r_high_water;
        if (i_cmd.commit) begin
            if (is_alloc) begin
                if (pop_ok) begin
                    n_free_count = r_free_count - CNT_W'(1);
                    n_free_head  = (r_free_count != CNT_W'(1)) ? {1'b0, link_rdata}
                                                               : HEAD_EMPTY;
                end else if (bump_ok) begin
                    n_high_water = r_high_water + CNT_W'(1);
                end
            end else if (rel_ok) begin
                n_free_head  = slot_ext;
                n_free_count = r_free_count + CNT_W'(1);
            end
        end

        if (i_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_head  <= HEAD_EMPTY;
            r_free_count <= '0;
            r_high_water <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_free_head  <= n_free_head;
            r_free_count <= n_free_count;
            r_high_water <= n_high_water;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_alloc_id <= alloc_ok ? grant_id : '0;
            if (is_alloc) begin
                r_status <= alloc_ok ? ST_OK : ST_FULL;
            end else begin
                r_status <= rel_ok ? ST_OK : ST_BAD_ID;
            end
        end
    end

    assign o_sts.out_busy = r_out_valid && !i_ready;
    assign o_valid        = r_out_valid;
    assign o_alloc_id     = r_alloc_id;
    assign o_status       = r_status;
endmodule

>>> rtl/slot_allocator_free_list.sv
// Slot allocator top level: request channel in, response channel out.
// Depends on safl_pkg, safl_if, safl_ctrl and safl_dp.
//
// Usage:
//   i_req carries op, page_word, offset_word and slot_id. op = alloc grants a
//   slot (reuse of the most recently released one first, else the next
//   never-used one) and stores the two payload words there. op = release
//   returns slot_id to the free list.
//   o_rsp carries one transfer per request: alloc_id (granted id, zero on
//   failure and on every release) and status (ok, full, bad id).
//   Each request has a capture step, the synchronous read of the head's
//   link and of the used map, then an update step for the lists and result.
//   i_req.ready is high in the cycle after a result is loaded, so a new
//   request may be taken while that result still waits on o_rsp.
//   Reset clears the free list, the high-water mark and the output valid;
//   the memories need no clearing pass, since read data from an entry is only
//   used after that entry has been written.
//   When the receiver stalls, the response holds, and a following request
//   waits in the update step until the response is taken.
module slot_allocator_free_list (
    input  logic         i_clk,
    input  logic         i_rst_n,
    safl_req_if.sink     i_req,
    safl_rsp_if.source   o_rsp
);
    import safl_pkg::*;

    t_cmd cmd;
    t_sts sts;

    safl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    safl_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_op          (i_req.op),
        .i_page_word   (i_req.page_word),
        .i_offset_word (i_req.offset_word),
        .i_slot_id     (i_req.slot_id),
        .o_valid       (o_rsp.valid),
        .i_ready       (o_rsp.ready),
        .o_alloc_id    (o_rsp.alloc_id),
        .o_status      (o_rsp.status)
    );
endmodule

>>> rtl/safl_checker.sv
// Port-level checks for the slot allocator, bound to the top level.
// Depends on safl_pkg and slot_allocator_free_list.
module safl_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic                      i_in_ready,
    input  logic                      i_out_valid,
    input  logic                      i_out_ready,
    input  logic [safl_pkg::ID_W-1:0] i_alloc_id,
    input  safl_pkg::t_status         i_status
);
    import safl_pkg::*;

    // a stalled response keeps its payload
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_alloc_id) && $stable(i_status)))
        else $error("response changed while stalled");

    // only a successful grant carries a nonzero id
    a_fail_zero_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_status != ST_OK)) |-> (i_alloc_id == '0))
        else $error("failed request returned a slot id");

    // one request in flight: no request is taken right after another
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("request taken in the update cycle");

    // reset empties the response register
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("response valid after reset");
endmodule

bind slot_allocator_free_list safl_checker u_safl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_alloc_id  (o_rsp.alloc_id),
    .i_status    (o_rsp.status)
);
